// ===== rtl/core/scp_pkg.sv =====
// scp_pkg: shared constants, types and register codes for segment_clip_project
// no dependencies; every rtl file refers to it by scoped names

package scp_pkg;

    // coordinate and screen widths
    localparam int COORD_W   = 32;
    localparam int PIX_W     = 41;
    localparam int OUT_W     = 15;
    localparam int WIDTH_W   = 13;
    localparam int CTR_W     = 12;
    localparam int K_W       = 29;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 13;

    // divider geometry: dividend, divisor and quotient widths
    localparam int DIV_N = 64;
    localparam int DIV_D = 48;
    localparam int DIV_Q = 40;

    // near plane 0.001 in q16.16, 0.7 in q0.16, interpolation fraction bits
    localparam logic signed [COORD_W-1:0] NEAR_Z = 32'sd66;
    localparam logic [15:0] SCALE_07  = 16'd45875;
    localparam int          FRAC_BITS = 30;

    // screen clamp limit
    localparam int CLIP_LIMIT = 10000;
    localparam logic [15:0]              LIM_U = 16'(CLIP_LIMIT);
    localparam logic signed [PIX_W-1:0]  LIM_P = PIX_W'(CLIP_LIMIT);
    localparam logic signed [PIX_W-1:0]  LIM_N = -LIM_P;

    // pipeline depths
    localparam int CLIP_LAT = DIV_Q + 4;
    localparam int LANE_LAT = 3 * DIV_Q + 7;
    localparam int PIPE_LAT = CLIP_LAT + LANE_LAT;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH = 2'd0,
        CFG_CENTER_X     = 2'd1,
        CFG_CENTER_Y     = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        t_point p0;
        t_point p1;
        logic   f0;
        logic   f1;
    } t_seg;

    typedef struct packed {
        logic [K_W-1:0]   k;
        logic [CTR_W-1:0] cx;
        logic [CTR_W-1:0] cy;
    } t_proj_cfg;

endpackage

// ===== rtl/core/segment_clip_project.sv =====
// segment_clip_project: near-plane clip and projection of one segment per word
// output valid is registered after the clip and lane pipelines; one segment per
// cycle throughput set by fully pipelined dividers (one quotient bit per stage)
// except that the whole pipeline holds while a finished word waits at the output
// synchronous reset clears the valid pipeline and sets width 640, center 320/240
// depends on scp_pkg, scp_div, scp_clip and scp_lane

module segment_clip_project (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [scp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [scp_pkg::CFG_W-1:0]         i_cfg_data,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z (32 bits each)
    input  logic [191:0]                      i_s_tdata,
    // output stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // screen_x1, screen_y1, screen_x2, screen_y2 (15 bits each), 4 bits zero
    output logic [63:0]                       o_m_tdata,
    // visible
    output logic                              o_m_tuser
);

    localparam int L = scp_pkg::PIPE_LAT;

    logic                                 en;
    logic                                 accept;
    logic [scp_pkg::WIDTH_W-1:0]          r_width;
    logic [scp_pkg::CTR_W-1:0]            r_cx;
    logic [scp_pkg::CTR_W-1:0]            r_cy;
    logic [scp_pkg::K_W-1:0]              r_k;
    scp_pkg::t_proj_cfg                   proj_cfg;
    scp_pkg::t_point                      in_p0;
    scp_pkg::t_point                      in_p1;
    scp_pkg::t_point                      clip_p0;
    scp_pkg::t_point                      clip_p1;
    logic [scp_pkg::OUT_W-1:0]            sx1;
    logic [scp_pkg::OUT_W-1:0]            sy1;
    logic [scp_pkg::OUT_W-1:0]            sx2;
    logic [scp_pkg::OUT_W-1:0]            sy2;
    logic                                 r_vld [L];
    logic                                 r_vis [L];
    logic                                 r_out_valid;
    logic                                 r_out_vis;
    logic [63:0]                          r_out_data;

    // pipeline moves whenever the output register is free or being taken
    assign en         = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && en;
    assign o_s_tready = en;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 13'd640;
            r_cx    <= 12'd320;
            r_cy    <= 12'd240;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                scp_pkg::CFG_SCREEN_WIDTH: r_width <= i_cfg_data;
                scp_pkg::CFG_CENTER_X:     r_cx    <= i_cfg_data[scp_pkg::CTR_W-1:0];
                scp_pkg::CFG_CENTER_Y:     r_cy    <= i_cfg_data[scp_pkg::CTR_W-1:0];
                default: ;
            endcase
        end
    end

    // projection scale 0.7 * width in q.16
    always_ff @(posedge i_clk) begin
        r_k <= scp_pkg::K_W'(r_width) * scp_pkg::K_W'(scp_pkg::SCALE_07);
    end

    assign proj_cfg = '{k: r_k, cx: r_cx, cy: r_cy};

    // unpack the input word
    always_comb begin
        in_p0.x = $signed(i_s_tdata[31:0]);
        in_p0.y = $signed(i_s_tdata[63:32]);
        in_p0.z = $signed(i_s_tdata[95:64]);
        in_p1.x = $signed(i_s_tdata[127:96]);
        in_p1.y = $signed(i_s_tdata[159:128]);
        in_p1.z = $signed(i_s_tdata[191:160]);
    end

    scp_clip u_clip (
        .i_clk (i_clk),
        .i_en  (en),
        .i_p0  (in_p0),
        .i_p1  (in_p1),
        .o_p0  (clip_p0),
        .o_p1  (clip_p1)
    );

    scp_lane u_lane0 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_pt  (clip_p0),
        .i_cfg (proj_cfg),
        .o_sx  (sx1),
        .o_sy  (sy1)
    );

    scp_lane u_lane1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_pt  (clip_p1),
        .i_cfg (proj_cfg),
        .o_sx  (sx2),
        .o_sy  (sy2)
    );

    // valid tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < L; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= accept;
            for (int s = 1; s < L; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // visibility flag travels beside the lanes
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vis[0] <= (in_p0.z > scp_pkg::NEAR_Z) || (in_p1.z > scp_pkg::NEAR_Z);
            for (int s = 1; s < L; s++) begin
                r_vis[s] <= r_vis[s-1];
            end
        end
    end

    // merge both lanes into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vld[L-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_vis  <= r_vis[L-1];
            r_out_data <= r_vis[L-1] ? {4'b0000, sy2, sx2, sy1, sx1} : 64'd0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_vis;

endmodule

// ===== rtl/core/scp_div.sv =====
// scp_div: pipelined restoring divider, one quotient bit per stage
// depends on scp_pkg for the divider widths

module scp_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [scp_pkg::DIV_N-1:0]    i_num,
    input  logic [scp_pkg::DIV_D-1:0]    i_den,
    output logic [scp_pkg::DIV_Q-1:0]    o_quo
);

    localparam int N = scp_pkg::DIV_N;
    localparam int D = scp_pkg::DIV_D;
    localparam int Q = scp_pkg::DIV_Q;

    logic [D-1:0] r_rem [Q];
    logic [Q-1:0] r_q   [Q];
    logic [D-1:0] r_den [Q];

    logic [D-1:0] a_rem [Q];
    logic [Q-1:0] a_q   [Q];
    logic [D-1:0] a_den [Q];
    logic [D-1:0] n_rem [Q];
    logic [Q-1:0] n_q   [Q];

    // stage inputs: the first stage takes the new word
    always_comb begin
        a_rem[0] = D'(i_num[N-1:Q]);
        a_q[0]   = i_num[Q-1:0];
        a_den[0] = i_den;
        for (int s = 1; s < Q; s++) begin
            a_rem[s] = r_rem[s-1];
            a_q[s]   = r_q[s-1];
            a_den[s] = r_den[s-1];
        end
    end

    // one compare and subtract per stage
    always_comb begin
        logic [D:0] rem_sh;
        logic       ge;
        rem_sh = '0;
        ge     = 1'b0;
        for (int s = 0; s < Q; s++) begin
            rem_sh   = {a_rem[s], a_q[s][Q-1]};
            ge       = rem_sh >= {1'b0, a_den[s]};
            n_rem[s] = ge ? D'(rem_sh - {1'b0, a_den[s]}) : rem_sh[D-1:0];
            n_q[s]   = {a_q[s][Q-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < Q; s++) begin
                r_rem[s] <= n_rem[s];
                r_q[s]   <= n_q[s];
                r_den[s] <= a_den[s];
            end
        end
    end

    assign o_quo = r_q[Q-1];

endmodule

// ===== rtl/core/scp_clip.sv =====
// scp_clip: near-plane test and interpolation of the end behind the plane
// depends on scp_pkg and scp_div

module scp_clip (
    input  logic            i_clk,
    input  logic            i_en,
    input  scp_pkg::t_point i_p0,
    input  scp_pkg::t_point i_p1,
    output scp_pkg::t_point o_p0,
    output scp_pkg::t_point o_p1
);

    localparam int Q = scp_pkg::DIV_Q;
    localparam logic signed [63:0] RND = (64'sd1 <<< scp_pkg::FRAC_BITS) - 64'sd1;

    logic                                f0;
    logic                                f1;
    logic signed [scp_pkg::COORD_W-1:0]  zb;
    logic signed [scp_pkg::COORD_W-1:0]  zf;
    logic signed [33:0]                  near_gap;
    logic signed [33:0]                  span;

    scp_pkg::t_seg                   r_c0_seg;
    logic [scp_pkg::DIV_N-1:0]       r_num;
    logic [scp_pkg::DIV_D-1:0]       r_den;
    logic [scp_pkg::DIV_Q-1:0]       quo;
    scp_pkg::t_seg                   r_dly [Q];

    scp_pkg::t_seg                   seg_d;
    scp_pkg::t_point                 cb;
    scp_pkg::t_point                 cf;
    scp_pkg::t_seg                   r_l1_seg;
    logic [scp_pkg::FRAC_BITS-1:0]   r_l1_t;
    logic signed [32:0]              r_l1_dx;
    logic signed [32:0]              r_l1_dy;

    scp_pkg::t_seg                   r_l2_seg;
    logic signed [63:0]              r_l2_mx;
    logic signed [63:0]              r_l2_my;

    scp_pkg::t_point                 cb2;
    logic signed [63:0]              adj_x;
    logic signed [63:0]              adj_y;
    logic signed [63:0]              off_x;
    logic signed [63:0]              off_y;
    scp_pkg::t_point                 moved;
    scp_pkg::t_point                 r_out_p0;
    scp_pkg::t_point                 r_out_p1;

    // pick the end behind the plane and set up t = gap * 2^30 / span
    always_comb begin
        f0       = i_p0.z > scp_pkg::NEAR_Z;
        f1       = i_p1.z > scp_pkg::NEAR_Z;
        zb       = f0 ? i_p1.z : i_p0.z;
        zf       = f0 ? i_p0.z : i_p1.z;
        near_gap = 34'(scp_pkg::NEAR_Z) - 34'(zb);
        span     = 34'(zf) - 34'(zb);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c0_seg <= '{p0: i_p0, p1: i_p1, f0: f0, f1: f1};
            r_num    <= {2'b00, near_gap[31:0], 30'd0};
            r_den    <= {16'd0, span[31:0]};
        end
    end

    scp_div u_div (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_num),
        .i_den (r_den),
        .o_quo (quo)
    );

    // segment delay alongside the divider
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dly[0] <= r_c0_seg;
            for (int s = 1; s < Q; s++) begin
                r_dly[s] <= r_dly[s-1];
            end
        end
    end

    // differences between the front and behind ends
    always_comb begin
        seg_d = r_dly[Q-1];
        cb    = seg_d.f0 ? seg_d.p1 : seg_d.p0;
        cf    = seg_d.f0 ? seg_d.p0 : seg_d.p1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l1_seg <= seg_d;
            r_l1_t   <= quo[scp_pkg::FRAC_BITS-1:0];
            r_l1_dx  <= 33'(cf.x) - 33'(cb.x);
            r_l1_dy  <= 33'(cf.y) - 33'(cb.y);
        end
    end

    // scale the differences by t
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l2_seg <= r_l1_seg;
            r_l2_mx  <= 64'(r_l1_dx) * 64'($signed({1'b0, r_l1_t}));
            r_l2_my  <= 64'(r_l1_dy) * 64'($signed({1'b0, r_l1_t}));
        end
    end

    // truncate toward zero and add to the behind end
    always_comb begin
        cb2   = r_l2_seg.f0 ? r_l2_seg.p1 : r_l2_seg.p0;
        adj_x = r_l2_mx + (r_l2_mx[63] ? RND : 64'sd0);
        adj_y = r_l2_my + (r_l2_my[63] ? RND : 64'sd0);
        off_x = adj_x >>> scp_pkg::FRAC_BITS;
        off_y = adj_y >>> scp_pkg::FRAC_BITS;
        moved.x = cb2.x + off_x[31:0];
        moved.y = cb2.y + off_y[31:0];
        moved.z = scp_pkg::NEAR_Z;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!r_l2_seg.f0) begin
                r_out_p0 <= moved;
                r_out_p1 <= r_l2_seg.p1;
            end else if (!r_l2_seg.f1) begin
                r_out_p0 <= r_l2_seg.p0;
                r_out_p1 <= moved;
            end else begin
                r_out_p0 <= r_l2_seg.p0;
                r_out_p1 <= r_l2_seg.p1;
            end
        end
    end

    assign o_p0 = r_out_p0;
    assign o_p1 = r_out_p1;

endmodule

// ===== rtl/core/scp_lane.sv =====
// scp_lane: perspective projection and screen clamp of one endpoint
// depends on scp_pkg and scp_div

module scp_lane (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  scp_pkg::t_point             i_pt,
    input  scp_pkg::t_proj_cfg          i_cfg,
    output logic [scp_pkg::OUT_W-1:0]   o_sx,
    output logic [scp_pkg::OUT_W-1:0]   o_sy
);

    localparam int Q  = scp_pkg::DIV_Q;
    localparam int PW = scp_pkg::PIX_W;

    typedef struct packed {
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic                 hit;
    } t_clamp;

    function automatic logic [PW-1:0] mag(input logic signed [PW-1:0] v);
        return v[PW-1] ? PW'(-v) : PW'(v);
    endfunction

    // magnitudes of x and y, signs kept aside
    logic [31:0]              r_p1_ax;
    logic [31:0]              r_p1_ay;
    logic                     r_p1_sx;
    logic                     r_p1_sy;
    logic [31:0]              r_p1_z;

    logic [60:0]              r_p2_mx;
    logic [60:0]              r_p2_my;
    logic [scp_pkg::DIV_D-1:0] r_p2_den;
    logic [1:0]               r_p2_sgn;

    logic [Q-1:0]             quo_x;
    logic [Q-1:0]             quo_y;
    logic [1:0]               r_d1 [Q];

    logic signed [PW-1:0]     qx_s;
    logic signed [PW-1:0]     qy_s;
    logic signed [PW-1:0]     r_a1_px;
    logic signed [PW-1:0]     r_a1_py;

    logic                     hit1;
    logic [scp_pkg::DIV_N-1:0] r_a2_num;
    logic [scp_pkg::DIV_D-1:0] r_a2_den;
    t_clamp                   r_a2;
    logic [Q-1:0]             quo1;
    t_clamp                   r_d2 [Q];

    logic signed [PW-1:0]     q1_s;
    t_clamp                   c2;
    logic signed [PW-1:0]     r_a3_px;
    logic signed [PW-1:0]     r_a3_py;

    logic                     hit2;
    logic [scp_pkg::DIV_N-1:0] r_a4_num;
    logic [scp_pkg::DIV_D-1:0] r_a4_den;
    t_clamp                   r_a4;
    logic [Q-1:0]             quo2;
    t_clamp                   r_d3 [Q];

    logic signed [PW-1:0]     q2_s;
    t_clamp                   c3;
    logic [scp_pkg::OUT_W-1:0] r_sx;
    logic [scp_pkg::OUT_W-1:0] r_sy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1_ax <= i_pt.x[31] ? (~i_pt.x + 32'd1) : i_pt.x;
            r_p1_ay <= i_pt.y[31] ? (~i_pt.y + 32'd1) : i_pt.y;
            r_p1_sx <= i_pt.x[31];
            r_p1_sy <= i_pt.y[31];
            r_p1_z  <= i_pt.z;
        end
    end

    // scale by 0.7 * width, depth moves to the divisor as z * 2^16
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p2_mx  <= 61'(i_cfg.k) * 61'(r_p1_ax);
            r_p2_my  <= 61'(i_cfg.k) * 61'(r_p1_ay);
            r_p2_den <= {r_p1_z, 16'd0};
            r_p2_sgn <= {r_p1_sx, r_p1_sy};
        end
    end

    scp_div u_div_x (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num ({3'b000, r_p2_mx}),
        .i_den (r_p2_den),
        .o_quo (quo_x)
    );

    scp_div u_div_y (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num ({3'b000, r_p2_my}),
        .i_den (r_p2_den),
        .o_quo (quo_y)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1[0] <= r_p2_sgn;
            for (int s = 1; s < Q; s++) begin
                r_d1[s] <= r_d1[s-1];
            end
        end
    end

    // restore signs, y is flipped, then add the view center
    always_comb begin
        qx_s = $signed({1'b0, quo_x});
        qy_s = $signed({1'b0, quo_y});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1_px <= (r_d1[Q-1][1] ? -qx_s : qx_s) + $signed(PW'(i_cfg.cx));
            r_a1_py <= (r_d1[Q-1][0] ? qy_s : -qy_s) + $signed(PW'(i_cfg.cy));
        end
    end

    // x outside the limit: y scales by limit / |x|
    assign hit1 = (r_a1_px < scp_pkg::LIM_N) || (r_a1_px > scp_pkg::LIM_P);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a2_num <= scp_pkg::DIV_N'(mag(r_a1_py)) * scp_pkg::DIV_N'(scp_pkg::LIM_U);
            r_a2_den <= scp_pkg::DIV_D'(mag(r_a1_px));
            r_a2     <= '{px: r_a1_px, py: r_a1_py, hit: hit1};
        end
    end

    scp_div u_div_c1 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_a2_num),
        .i_den (r_a2_den),
        .o_quo (quo1)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d2[0] <= r_a2;
            for (int s = 1; s < Q; s++) begin
                r_d2[s] <= r_d2[s-1];
            end
        end
    end

    always_comb begin
        c2   = r_d2[Q-1];
        q1_s = $signed({1'b0, quo1});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (c2.hit) begin
                r_a3_py <= c2.py[PW-1] ? -q1_s : q1_s;
                r_a3_px <= c2.px[PW-1] ? scp_pkg::LIM_N : scp_pkg::LIM_P;
            end else begin
                r_a3_py <= c2.py;
                r_a3_px <= c2.px;
            end
        end
    end

    // y outside the limit: x scales by limit / |y|
    assign hit2 = (r_a3_py < scp_pkg::LIM_N) || (r_a3_py > scp_pkg::LIM_P);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a4_num <= scp_pkg::DIV_N'(mag(r_a3_px)) * scp_pkg::DIV_N'(scp_pkg::LIM_U);
            r_a4_den <= scp_pkg::DIV_D'(mag(r_a3_py));
            r_a4     <= '{px: r_a3_px, py: r_a3_py, hit: hit2};
        end
    end

    scp_div u_div_c2 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_a4_num),
        .i_den (r_a4_den),
        .o_quo (quo2)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d3[0] <= r_a4;
            for (int s = 1; s < Q; s++) begin
                r_d3[s] <= r_d3[s-1];
            end
        end
    end

    always_comb begin
        c3   = r_d3[Q-1];
        q2_s = $signed({1'b0, quo2});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (c3.hit) begin
                r_sx <= c3.px[PW-1] ? -q2_s[scp_pkg::OUT_W-1:0] : q2_s[scp_pkg::OUT_W-1:0];
                r_sy <= c3.py[PW-1] ? scp_pkg::LIM_N[scp_pkg::OUT_W-1:0]
                                    : scp_pkg::LIM_P[scp_pkg::OUT_W-1:0];
            end else begin
                r_sx <= c3.px[scp_pkg::OUT_W-1:0];
                r_sy <= c3.py[scp_pkg::OUT_W-1:0];
            end
        end
    end

    assign o_sx = r_sx;
    assign o_sy = r_sy;

endmodule

// ===== tb/segment_clip_project_tb.sv =====
// segment_clip_project_tb: self-checking testbench for the segment clip and projection block
// depends on scp_pkg and the segment_clip_project rtl; has its own fixed-point projection model

module segment_clip_project_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 172;
    localparam int NUM_RANDOM = 1750;
    localparam int SINK_HOLD = 600;

    typedef struct packed {
        logic signed [31:0] ez;
        logic signed [31:0] ey;
        logic signed [31:0] ex;
        logic signed [31:0] sz;
        logic signed [31:0] sy;
        logic signed [31:0] sx;
    } t_segment;

    typedef struct {
        logic        vis;
        logic [14:0] x1;
        logic [14:0] y1;
        logic [14:0] x2;
        logic [14:0] y2;
    } t_screen;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_idx;
    logic [12:0]  i_cfg_data;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [191:0] i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [63:0]  o_m_tdata;
    logic         o_m_tuser;

    segment_clip_project u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // model copy of the view registers
    longint view_width = 640;
    longint view_cx = 320;
    longint view_cy = 240;

    t_segment seg_queue[$];
    t_screen  screen_queue[$];
    int  mismatches = 0;
    int  words_out = 0;
    int  visible_count = 0;
    bit  hold_sink = 0;
    int  seg_gap = 0;
    bit  in_taken = 0;
    bit  out_taken = 0;

    // clock
    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // c-style truncating division of 64-bit values
    function automatic longint tdiv(longint n, longint d);
        return n / d;
    endfunction

    // perspective projection of one point with screen clamp
    function automatic void project_point(longint x, longint y, longint z,
                                          output longint sx, output longint sy);
        longint k, den, px, py, lim, ax;
        k = 45875 * view_width;
        den = z * 65536;
        lim = scp_pkg::CLIP_LIMIT;
        px = tdiv(k * x, den) + view_cx;
        py = -tdiv(k * y, den) + view_cy;
        if (px < -lim || px > lim) begin
            ax = (px < 0) ? -px : px;
            py = tdiv(py * lim, ax);
            px = (px < 0) ? -lim : lim;
        end
        if (py < -lim || py > lim) begin
            ax = (py < 0) ? -py : py;
            px = tdiv(px * lim, ax);
            py = (py < 0) ? -lim : lim;
        end
        sx = px;
        sy = py;
    endfunction

    // clip against the near plane, then project both ends
    function automatic t_screen clip_project(t_segment s);
        t_screen r;
        longint x0, y0, z0, x1, y1, z1, t, a, b, c, d;
        bit f0, f1;
        x0 = s.sx; y0 = s.sy; z0 = s.sz;
        x1 = s.ex; y1 = s.ey; z1 = s.ez;
        f0 = z0 > 66;
        f1 = z1 > 66;
        r = '{1'b0, 15'd0, 15'd0, 15'd0, 15'd0};
        if (!f0 && !f1) return r;
        if (!f0) begin
            t = tdiv((66 - z0) * (64'sd1 <<< 30), z1 - z0);
            x0 = x0 + tdiv((x1 - x0) * t, 64'sd1 <<< 30);
            y0 = y0 + tdiv((y1 - y0) * t, 64'sd1 <<< 30);
            z0 = 66;
        end else if (!f1) begin
            t = tdiv((66 - z1) * (64'sd1 <<< 30), z0 - z1);
            x1 = x1 + tdiv((x0 - x1) * t, 64'sd1 <<< 30);
            y1 = y1 + tdiv((y0 - y1) * t, 64'sd1 <<< 30);
            z1 = 66;
        end
        project_point(x0, y0, z0, a, b);
        project_point(x1, y1, z1, c, d);
        r.vis = 1'b1;
        r.x1 = a[14:0];
        r.y1 = b[14:0];
        r.x2 = c[14:0];
        r.y2 = d[14:0];
        return r;
    endfunction

    // handshakes as seen at the rising edge
    always @(posedge i_clk) begin
        in_taken  <= i_s_tvalid && o_s_tready;
        out_taken <= o_m_tvalid && i_m_tready;
    end

    // driver: offers queued segments with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && !in_taken) begin
            // hold the offered word
        end else begin
            if (i_s_tvalid) begin
                screen_queue.push_back(clip_project(t_segment'(i_s_tdata)));
                void'(seg_queue.pop_front());
                seg_gap = $urandom_range(0, 14);
                if ($urandom_range(0, 3) == 0) seg_gap = 0;
            end
            if (seg_queue.size() > 0 && seg_gap == 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata <= seg_queue[0];
            end else begin
                i_s_tvalid <= 1'b0;
                if (seg_gap > 0) seg_gap--;
            end
        end
    end

    // acceptance is seen on the rising edge, the model update is done above at the next fall
    // sink ready with random stalls, or held low for a long stretch
    int sink_wait = 0;
    int hold_cnt = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_sink && hold_cnt < SINK_HOLD) begin
            hold_cnt++;
            i_m_tready <= 1'b0;
        end else if (sink_wait > 0) begin
            sink_wait--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (out_taken)
                sink_wait = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
        end
    end

    // monitor: compares each output word with the oldest prediction
    always @(posedge i_clk) begin
        t_screen e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            words_out++;
            if (o_m_tuser) visible_count++;
            if (screen_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output word %h", o_m_tdata);
            end else begin
                e = screen_queue.pop_front();
                if (o_m_tuser !== e.vis || o_m_tdata[14:0] !== e.x1 ||
                    o_m_tdata[29:15] !== e.y1 || o_m_tdata[44:30] !== e.x2 ||
                    o_m_tdata[59:45] !== e.y2 || o_m_tdata[63:60] !== 4'd0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp vis %0b %h %h %h %h, got vis %0b %h",
                                 e.vis, e.x1, e.y1, e.x2, e.y2, o_m_tuser, o_m_tdata);
                end
            end
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            2: return 32'($signed($urandom_range(0, 400000)) - 200000);
            3: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
            default: return 32'($signed($urandom_range(0, 200)) - 100) <<< 16;
        endcase
    endfunction

    function automatic logic [31:0] rand_depth();
        case ($urandom_range(0, 6))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8)) + 62);
            2: return 32'($signed($urandom_range(0, 4000)) - 1000) <<< 12;
            3: return -(32'($urandom_range(0, 100)) <<< 16);
            default: return 32'($urandom_range(1, 500)) <<< 16;
        endcase
    endfunction

    function automatic t_segment rand_segment();
        t_segment s;
        s.sx = rand_coord(); s.sy = rand_coord(); s.sz = rand_depth();
        s.ex = rand_coord(); s.ey = rand_coord(); s.ez = rand_depth();
        return s;
    endfunction

    task automatic wait_drained();
        while (seg_queue.size() > 0 || i_s_tvalid || screen_queue.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(scp_pkg::t_cfg_idx idx, logic [12:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            scp_pkg::CFG_SCREEN_WIDTH: view_width = val;
            scp_pkg::CFG_CENTER_X:     view_cx = val;
            default:                   view_cy = val;
        endcase
    endtask

    task automatic push_random(int n);
        repeat (n) seg_queue.push_back(rand_segment());
    endtask

    // stimulus
    initial begin
        t_segment s;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = scp_pkg::CFG_SCREEN_WIDTH;
        i_cfg_data = 0;
        i_s_tvalid = 0;
        i_s_tdata = '0;
        i_m_tready = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: reset config, near-plane edges, clipping each end, clamps
        s = '{32'sd66, 32'sd0, 32'sd0, 32'sd66, 32'sd0, 32'sd0};       seg_queue.push_back(s);
        s = '{32'sd67, 32'sd0, 32'sd0, 32'sd66, 32'sd0, 32'sd0};       seg_queue.push_back(s);
        s = '{32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536, -32'sd65536, -32'sd65536};
        seg_queue.push_back(s);
        s = '{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
              -32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};        seg_queue.push_back(s);
        s = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000,
              32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};         seg_queue.push_back(s);
        s = '{32'sd67, 32'sh7fffffff, 32'sh7fffffff,
              32'sh80000000, 32'sh80000000, 32'sh80000000};         seg_queue.push_back(s);
        s = '{32'sd100 <<< 16, 32'sd0, 32'sd5 <<< 16,
              32'sd1 <<< 16, 32'sd3 <<< 16, -32'sd2 <<< 16};        seg_queue.push_back(s);
        s = '{-32'sd10 <<< 16, 32'sd1 <<< 16, 32'sd1 <<< 16,
              32'sd10 <<< 16, 32'sd2 <<< 16, 32'sd2 <<< 16};        seg_queue.push_back(s);
        s = '{32'sh7fffffff, 32'sd0, 32'sd0, 32'sh7fffffff, 32'sd0, 32'sd0};
        seg_queue.push_back(s);
        s = '{32'sd67, 32'sd1000 <<< 16, 32'sd10 <<< 16,
              32'sd67, -32'sd1000 <<< 16, 32'sd20 <<< 16};          seg_queue.push_back(s);
        wait_drained();

        // zero width and extreme centers
        write_reg(scp_pkg::CFG_SCREEN_WIDTH, 13'd0);
        write_reg(scp_pkg::CFG_CENTER_X, 12'd4095);
        write_reg(scp_pkg::CFG_CENTER_Y, 12'd0);
        seg_queue.push_back('{32'sd65536, 32'sd5 <<< 16, -32'sd7 <<< 16,
                              32'sd67, 32'sd9, 32'sd9});
        push_random(60);
        wait_drained();

        // width 4096, long sink hold so the pipeline backs up
        write_reg(scp_pkg::CFG_SCREEN_WIDTH, 13'd4096);
        write_reg(scp_pkg::CFG_CENTER_X, 12'd0);
        write_reg(scp_pkg::CFG_CENTER_Y, 12'd4095);
        hold_sink = 1;
        push_random(300);
        wait (hold_cnt == SINK_HOLD);
        hold_sink = 0;
        wait_drained();

        // several random settings
        for (int p = 0; p < 6; p++) begin
            write_reg(scp_pkg::CFG_SCREEN_WIDTH, 13'($urandom_range(1, 4096)));
            write_reg(scp_pkg::CFG_CENTER_X, 12'($urandom()));
            write_reg(scp_pkg::CFG_CENTER_Y, 12'($urandom()));
            if (p == 5) write_reg(scp_pkg::CFG_SCREEN_WIDTH, 13'd1);
            push_random((NUM_RANDOM - 360) / 6);
            wait_drained();
        end

        $display("covered %0d output words, %0d visible, over zero, minimum, maximum and random",
                 words_out, visible_count);
        $display("view widths with clipping of either end and screen clamps");
        if (mismatches == 0 && screen_queue.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // run limit
    initial begin
        #8ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/scp_pkg.sv
rtl/core/scp_div.sv
rtl/core/scp_clip.sv
rtl/core/scp_lane.sv
rtl/core/segment_clip_project.sv
tb/segment_clip_project_tb.sv
